// ===== hw/rtl/digest_key_offset_table_assert.svh =====
// Assertion macros used by the checker file of the digest key offset table.
`ifndef DIGEST_KEY_OFFSET_TABLE_ASSERT_SVH
`define DIGEST_KEY_OFFSET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DKOT_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("digest_key_offset_table: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DKOT_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("digest_key_offset_table: assertion failed");

`endif

// ===== hw/rtl/dkot_pkg.sv =====
package dkot_pkg;

	localparam int TABLE_SLOTS_DEF   = 1024;
	localparam int DIGEST_PROBES_DEF = 4;

	localparam int CNT_W  = 11;
	localparam int WORD_W = 64;
	localparam int STAT_W = 32;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd768;

	// Register index as decoded from paddr[2].
	localparam logic CFG_IDX_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_GET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_NO_SLOT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic [WORD_W-1:0]         digest_w0;
		logic [WORD_W-1:0]         digest_w1;
		logic [WORD_W-1:0]         digest_w2;
		logic [WORD_W-1:0]         digest_w3;
		logic signed [WORD_W-1:0]  offset_in;
	} in_t;

	typedef struct packed {
		status_t                   status;
		logic signed [WORD_W-1:0]  offset_out;
		logic [CNT_W-1:0]          entry_count;
		logic signed [WORD_W-1:0]  max_offset;
		logic [STAT_W-1:0]         search_count;
		logic [STAT_W-1:0]         probe_count;
	} out_t;

endpackage

// ===== hw/rtl/digest_key_offset_table.sv =====
// Digest key offset table. Requests carry a command and a 256-bit key digest
// (four 64-bit words); put records an offset for the digest, keeping the
// larger of the stored and new values, get returns the stored offset, and
// clear empties the table and zeroes the statistics. Each request yields
// exactly one response with a status, the entry count, the greatest offset
// since the last clear and saturating search and probe counters. The slots
// live in a single-port digest memory and an offset memory; one slot is read
// per probe, so the search is the limiting loop. For a power-of-two table size
// a digest probe goes through index, read and compare, and each linear probe
// through read and compare only; for other sizes the index of a digest probe
// comes from a shared 4-bit-per-cycle remainder unit. Clear sweeps the digest
// memory one slot per cycle, and the same sweep runs after reset, during
// which in_ready stays low. The block works on one request at a time, but a
// finished response waits in its own register so that the next request may
// be accepted before it is taken. The capacity register sits at byte address
// 0 of the APB port and must only be written while the block is idle.
module digest_key_offset_table #(
	parameter int TABLE_SLOTS   = dkot_pkg::TABLE_SLOTS_DEF,
	parameter int DIGEST_PROBES = dkot_pkg::DIGEST_PROBES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dkot_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output dkot_pkg::out_t  out_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	// Slot index width, and the width of the probe counter, which runs over
	// the digest probes followed by one full lap of the table.
	localparam int  IDXW    = $clog2(TABLE_SLOTS);
	localparam int  CW      = $clog2(DIGEST_PROBES + TABLE_SLOTS);
	localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam int  TW      = IDXW + 4;

	localparam logic [IDXW-1:0] IDX_LAST   = IDXW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0]   PRB_LAST   = CW'(DIGEST_PROBES + TABLE_SLOTS - 1);
	localparam logic [CW-1:0]   PRB_DLAST  = CW'(DIGEST_PROBES - 1);

	dkot_pkg::state_t state_q, state_d;

	// Request held for the duration of the search.
	dkot_pkg::cmd_t                     cmd_q;
	logic [dkot_pkg::WORD_W-1:0]        key_q [4];
	logic signed [dkot_pkg::WORD_W-1:0] off_q;

	// Search progress.
	logic [CW-1:0]    probe_q;
	logic [IDXW-1:0]  idx_q;
	logic [IDXW-1:0]  rem_q;
	logic [3:0]       dgt_q;
	logic             clr_reply_q;

	// Result under construction and statistics.
	dkot_pkg::status_t                  status_q;
	logic signed [dkot_pkg::WORD_W-1:0] found_q;
	logic [dkot_pkg::CNT_W-1:0]         count_q;
	logic signed [dkot_pkg::WORD_W-1:0] max_q;
	logic [dkot_pkg::STAT_W-1:0]        searches_q;
	logic [dkot_pkg::STAT_W-1:0]        probes_q;
	logic [dkot_pkg::CNT_W-1:0]         cap_q;

	// Response register.
	logic            out_valid_q;
	dkot_pkg::out_t  out_q;

	// Slot memories and their registered read data.
	logic [4*dkot_pkg::WORD_W-1:0]      dig_mem [TABLE_SLOTS];
	logic [dkot_pkg::WORD_W-1:0]        off_mem [TABLE_SLOTS];
	logic [4*dkot_pkg::WORD_W-1:0]      rd_dig_q;
	logic signed [dkot_pkg::WORD_W-1:0] rd_off_q;

	logic [4*dkot_pkg::WORD_W-1:0] key_flat;
	logic [dkot_pkg::WORD_W-1:0]   hash_word;
	logic [3:0]                    hash_digit;
	logic [IDXW-1:0]               rem_next;

	logic accept;
	logic is_put;
	logic full;
	logic hit_empty;
	logic hit_match;
	logic off_gt_slot;
	logic off_gt_max;
	logic search_end;
	logic ins_new;
	logic raise_slot;
	logic dig_we;
	logic off_we;
	logic out_load;
	logic cfg_wr;

	assign accept   = in_valid && in_ready;
	assign key_flat = {key_q[3], key_q[2], key_q[1], key_q[0]};

	// Compare of the slot just read against the key in hand.
	assign is_put      = cmd_q == dkot_pkg::CMD_PUT;
	assign full        = count_q >= cap_q;
	assign hit_empty   = rd_dig_q == '0;
	assign hit_match   = rd_dig_q == key_flat;
	assign off_gt_slot = off_q > rd_off_q;
	assign off_gt_max  = off_q > max_q;
	assign search_end  = hit_empty || hit_match || probe_q == PRB_LAST;

	// A new key goes into the first empty slot unless the table is at
	// capacity; a matching key only ever has its offset raised.
	assign ins_new    = is_put && hit_empty && !full;
	assign raise_slot = is_put && !hit_empty && hit_match && off_gt_slot;

	// Index of a digest probe. The word is consumed four bits at a time from
	// the top, keeping a running remainder that is always below TABLE_SLOTS.
	assign hash_word  = key_q[probe_q[1:0]];
	assign hash_digit = hash_word[{~dgt_q, 2'b00} +: 4];

	always_comb begin
		logic [TW-1:0] t;
		logic [TW-1:0] m;
		t = {rem_q, hash_digit};
		for (int k = 3; k >= 0; k--) begin
			m = TW'(TABLE_SLOTS) << k;
			if (t >= m) begin
				t = t - m;
			end
		end
		rem_next = t[IDXW-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dkot_pkg::S_CLEAR: begin
				if (idx_q == IDX_LAST) begin
					state_d = clr_reply_q ? dkot_pkg::S_DONE : dkot_pkg::S_IDLE;
				end
			end
			dkot_pkg::S_IDLE: begin
				if (accept) begin
					case (in_data.cmd)
						dkot_pkg::CMD_PUT, dkot_pkg::CMD_GET: state_d = dkot_pkg::S_HASH;
						dkot_pkg::CMD_CLEAR:                  state_d = dkot_pkg::S_CLEAR;
						default:                              state_d = dkot_pkg::S_DONE;
					endcase
				end
			end
			dkot_pkg::S_HASH: begin
				if (IS_POW2 || dgt_q == 4'hF) begin
					state_d = dkot_pkg::S_READ;
				end
			end
			dkot_pkg::S_READ: begin
				state_d = dkot_pkg::S_CHECK;
			end
			dkot_pkg::S_CHECK: begin
				if (search_end) begin
					state_d = dkot_pkg::S_DONE;
				end else if (probe_q < PRB_DLAST) begin
					state_d = dkot_pkg::S_HASH;
				end else begin
					state_d = dkot_pkg::S_READ;
				end
			end
			dkot_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = dkot_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dkot_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		dig_we   = 1'b0;
		off_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			dkot_pkg::S_CLEAR: begin
				dig_we = 1'b1;
			end
			dkot_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			dkot_pkg::S_CHECK: begin
				dig_we = ins_new;
				off_we = ins_new || raise_slot;
			end
			dkot_pkg::S_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Slot memories: one write and one read port each, read data registered.
	// The clearing sweep writes zero digests through the same port.
	always_ff @(posedge clk) begin
		if (dig_we) begin
			dig_mem[idx_q] <= (state_q == dkot_pkg::S_CLEAR) ? '0 : key_flat;
		end
		if (off_we) begin
			off_mem[idx_q] <= off_q;
		end
		rd_dig_q <= dig_mem[idx_q];
		rd_off_q <= off_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dkot_pkg::S_CLEAR;
			idx_q       <= '0;
			probe_q     <= '0;
			rem_q       <= '0;
			dgt_q       <= '0;
			clr_reply_q <= 1'b0;
			count_q     <= '0;
			max_q       <= {1'b1, {(dkot_pkg::WORD_W-1){1'b0}}};
			searches_q  <= '0;
			probes_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				dkot_pkg::S_CLEAR: begin
					idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
				end
				dkot_pkg::S_IDLE: begin
					if (accept) begin
						probe_q <= '0;
						rem_q   <= '0;
						dgt_q   <= '0;
						if (in_data.cmd == dkot_pkg::CMD_CLEAR) begin
							idx_q       <= '0;
							clr_reply_q <= 1'b1;
							count_q     <= '0;
							max_q       <= {1'b1, {(dkot_pkg::WORD_W-1){1'b0}}};
							searches_q  <= '0;
							probes_q    <= '0;
						end else if (in_data.cmd == dkot_pkg::CMD_PUT ||
								in_data.cmd == dkot_pkg::CMD_GET) begin
							if (searches_q != '1) begin
								searches_q <= searches_q + 1'b1;
							end
						end
					end
				end
				dkot_pkg::S_HASH: begin
					if (IS_POW2) begin
						idx_q <= hash_word[IDXW-1:0];
					end else begin
						rem_q <= rem_next;
						dgt_q <= dgt_q + 1'b1;
						if (dgt_q == 4'hF) begin
							idx_q <= rem_next;
						end
					end
				end
				dkot_pkg::S_READ: begin
					if (probes_q != '1) begin
						probes_q <= probes_q + 1'b1;
					end
				end
				dkot_pkg::S_CHECK: begin
					if (ins_new) begin
						count_q <= count_q + 1'b1;
					end
					if ((ins_new || raise_slot) && off_gt_max) begin
						max_q <= off_q;
					end
					if (!search_end) begin
						probe_q <= probe_q + 1'b1;
						rem_q   <= '0;
						dgt_q   <= '0;
						// The linear walk starts at the slot of the last digest
						// probe, so that slot is read a second time.
						if (probe_q >= PRB_DLAST) begin
							if (probe_q != PRB_DLAST) begin
								idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
							end
						end
					end
				end
				dkot_pkg::S_DONE: begin
					clr_reply_q <= 1'b0;
				end
				default: begin
					clr_reply_q <= 1'b0;
				end
			endcase
		end
	end

	// Request payload and the result fields that follow it.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_data.cmd;
			key_q[0] <= in_data.digest_w0;
			key_q[1] <= in_data.digest_w1;
			key_q[2] <= in_data.digest_w2;
			key_q[3] <= in_data.digest_w3;
			off_q    <= in_data.offset_in;
			found_q  <= '0;
			case (in_data.cmd)
				dkot_pkg::CMD_PUT: status_q <= dkot_pkg::ST_NO_SLOT;
				dkot_pkg::CMD_GET: status_q <= dkot_pkg::ST_NOT_FOUND;
				default:           status_q <= dkot_pkg::ST_OK;
			endcase
		end else if (state_q == dkot_pkg::S_CHECK) begin
			if (hit_empty) begin
				if (!is_put) begin
					status_q <= dkot_pkg::ST_NOT_FOUND;
				end else if (full) begin
					status_q <= dkot_pkg::ST_FULL;
				end else begin
					status_q <= dkot_pkg::ST_OK;
				end
			end else if (hit_match) begin
				status_q <= dkot_pkg::ST_OK;
				if (!is_put) begin
					found_q <= rd_off_q;
				end
			end
		end
	end

	// Response register: the finished result waits here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.status       <= status_q;
			out_q.offset_out   <= found_q;
			out_q.entry_count  <= count_q;
			out_q.max_offset   <= max_q;
			out_q.search_count <= searches_q;
			out_q.probe_count  <= probes_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration port. The only register is the capacity, at byte address
	// zero; the low two address bits select a byte lane and are not decoded.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dkot_pkg::CAPACITY_RESET;
		end else if (cfg_wr && paddr[2] == dkot_pkg::CFG_IDX_CAPACITY) begin
			cap_q <= pwdata[dkot_pkg::CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == dkot_pkg::CFG_IDX_CAPACITY) ?
			{{(32-dkot_pkg::CNT_W){1'b0}}, cap_q} : '0;

endmodule

// ===== hw/rtl/dkot_checker.sv =====
`include "digest_key_offset_table_assert.svh"

module dkot_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input dkot_pkg::out_t  out_data,
	input logic            pready
);

	// A stalled response keeps its valid and its fields.
	`DKOT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// The block works on one request at a time, so it never takes two in a row.
	`DKOT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

	// Only a successful get carries an offset; every other status reports zero.
	`DKOT_ASSERT_IMP(a_offset_zero, clk, arst_n, out_valid && out_data.status != dkot_pkg::ST_OK, out_data.offset_out == '0)

	// The configuration port never inserts wait states.
	`DKOT_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind digest_key_offset_table dkot_checker u_dkot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.pready    (pready)
);

// ===== tb/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dkot_pkg::*;

	// Geometry of the table under test; the block runs with its defaults.
	localparam int SLOTS  = TABLE_SLOTS_DEF;
	localparam int PROBES = DIGEST_PROBES_DEF;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 11;
	// A quiet spell after the last response before the capacity is touched.
	localparam int SETTLE_CYCLES = 8;
	// Cycles to watch for stray responses once everything has come back.
	localparam int TAIL_CYCLES = 64;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int LONG_HOLD = 400;
	// The limit must cover a search over the whole table and a clear, plus the
	// long hold-off and the worst sender gap, several times over.
	localparam int STALL_LIMIT = 20000;
	// Mismatch reports beyond this many are counted but no longer printed.
	localparam int REPORT_LIMIT = 40;

	localparam logic [2:0] CAPACITY_ADDR = {CFG_IDX_CAPACITY, 2'b00};
	localparam logic [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};

	// A key digest as four words, word 0 in the lowest position.
	typedef bit [3:0][WORD_W-1:0] digest_t;

	// Shadow of the table. Every accepted request is applied here at once and
	// the response it must produce is queued; responses are then matched
	// against that queue in order.
	class offset_table_tracker;
		digest_t                slot_key [SLOTS];
		bit signed [WORD_W-1:0] slot_off [SLOTS];
		bit [CNT_W-1:0]         entries;
		bit signed [WORD_W-1:0] top_offset;
		bit [STAT_W-1:0]        searches;
		bit [STAT_W-1:0]        probes;
		bit [CNT_W-1:0]         capacity;
		out_t                   pending_resps [$];
		digest_t                stored_keys [$];
		int unsigned            failures;
		int unsigned            reported;
		int unsigned            cmd_seen [4];
		int unsigned            status_seen [4];

		function new();
			capacity = CAPACITY_RESET;
			wipe();
		endfunction

		function void wipe();
			foreach (slot_key[i])
				slot_key[i] = '0;
			entries = '0;
			top_offset = MOST_NEG;
			searches = '0;
			probes = '0;
			stored_keys.delete();
		endfunction

		function void note_request(in_t req);
			out_t                   resp;
			digest_t                key;
			bit signed [WORD_W-1:0] off;
			bit                     is_put;
			bit                     full;
			int unsigned            base;
			int unsigned            idx;
			int                     i;
			key = {req.digest_w3, req.digest_w2, req.digest_w1, req.digest_w0};
			off = req.offset_in;
			resp = '0;
			resp.status = ST_OK;
			cmd_seen[req.cmd]++;
			case (req.cmd)
				CMD_CLEAR: begin
					wipe();
				end
				CMD_PUT, CMD_GET: begin
					is_put = (req.cmd == CMD_PUT);
					full = (entries >= capacity);
					base = key[PROBES-1] % SLOTS;
					resp.status = is_put ? ST_NO_SLOT : ST_NOT_FOUND;
					if (searches != '1)
						searches++;
					for (i = 0; i < PROBES + SLOTS; i++) begin
						if (i < PROBES)
							idx = key[i] % SLOTS;
						else
							idx = (base + i - PROBES) % SLOTS;
						if (probes != '1)
							probes++;
						if (slot_key[idx] == '0) begin
							if (!is_put) begin
								resp.status = ST_NOT_FOUND;
							end else if (full) begin
								resp.status = ST_FULL;
							end else begin
								// A zero digest is written back as zero, so the
								// slot still reads as empty afterwards.
								slot_key[idx] = key;
								slot_off[idx] = off;
								entries++;
								if (off > top_offset)
									top_offset = off;
								if (key != '0)
									stored_keys.push_back(key);
								resp.status = ST_OK;
							end
							break;
						end
						if (slot_key[idx] == key) begin
							if (is_put) begin
								if (off > slot_off[idx]) begin
									slot_off[idx] = off;
									if (off > top_offset)
										top_offset = off;
								end
							end else begin
								resp.offset_out = slot_off[idx];
							end
							resp.status = ST_OK;
							break;
						end
					end
				end
				default: ;
			endcase
			resp.entry_count = entries;
			resp.max_offset = top_offset;
			resp.search_count = searches;
			resp.probe_count = probes;
			pending_resps.push_back(resp);
		endfunction

		function void compare_field(string name, logic [WORD_W-1:0] want,
				logic [WORD_W-1:0] got);
			if (got !== want) begin
				failures++;
				if (reported < REPORT_LIMIT) begin
					reported++;
					$error("%s mismatch: expected %0h, got %0h", name, want, got);
				end
			end
		endfunction

		function void check_response(out_t got);
			out_t want;
			if (pending_resps.size() == 0) begin
				failures++;
				$error("response arrived with no request outstanding");
				return;
			end
			want = pending_resps.pop_front();
			status_seen[want.status]++;
			compare_field("status", want.status, got.status);
			compare_field("offset_out", want.offset_out, got.offset_out);
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("max_offset", want.max_offset, got.max_offset);
			compare_field("search_count", want.search_count, got.search_count);
			compare_field("probe_count", want.probe_count, got.probe_count);
		endfunction

		// A random empty slot, or -1 when the table has none.
		function int free_slot();
			int unsigned start;
			int unsigned j;
			start = $urandom_range(0, SLOTS - 1);
			for (j = 0; j < SLOTS; j++)
				if (slot_key[(start + j) % SLOTS] == '0)
					return (start + j) % SLOTS;
			return -1;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	offset_table_tracker table_model;

	// Sender pacing: bursts of back-to-back requests separated by gaps. While
	// steady_send is set the gaps are skipped altogether.
	int unsigned burst_left = 0;
	bit          steady_send = 1'b0;
	// Each increment asks the receiver for one long hold-off.
	int unsigned hold_req = 0;
	int unsigned idle_cycles = 0;

	digest_t     key_pool [$];
	int unsigned pool_base;

	digest_key_offset_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Every response taken by the receiver is checked against the oldest
	// outstanding expectation. Signals are read straight after the edge,
	// before any of this edge's updates land, so they hold their pre-edge
	// values.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			table_model.check_response(out_data);
	end

	// The watchdog ends the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no request or response for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// The receiver changes its stall rate every stretch of cycles, from never
	// stalling to stalling most of the time. A long hold-off, when asked for,
	// overrides the pattern and is counted down here.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned holds_served;
		int unsigned stretch_left;
		int unsigned stall_pct;
		hold_left = 0;
		holds_served = 0;
		stretch_left = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_served) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(16, 128);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				stretch_left--;
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// A random word whose probe index lands on the given slot.
	function automatic logic [WORD_W-1:0] word_at(int unsigned slot);
		logic [WORD_W-1:0] w;
		w = rand_word();
		return w - (w % SLOTS) + slot;
	endfunction

	function automatic digest_t fresh_key();
		return {rand_word(), rand_word(), rand_word(), rand_word()};
	endfunction

	// Keys whose probe indices crowd into a sixteen-slot window, so that
	// searches collide and run on linearly, sometimes across the wrap.
	// Now and then a word is zero, which must not make the key look empty.
	function automatic digest_t pool_key(int unsigned base);
		digest_t key;
		int      w;
		for (w = 0; w < 4; w++)
			key[w] = ($urandom_range(0, 7) == 0) ? 64'd0 :
				word_at((base + $urandom_range(0, 15)) % SLOTS);
		return key;
	endfunction

	// Offsets lean towards the extremes and towards small values either side
	// of zero, where the signed comparison is most easily got wrong.
	function automatic logic [WORD_W-1:0] rand_offset();
		logic [WORD_W-1:0] near_zero;
		near_zero = $urandom_range(0, 2000);
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return $urandom_range(0, 1) ? 64'd0 : '1;
			3, 4, 5: return near_zero - 64'd1000;
			default: return rand_word();
		endcase
	endfunction

	function automatic in_t make_req(cmd_t cmd, digest_t key, logic [WORD_W-1:0] off);
		in_t req;
		req.cmd = cmd;
		req.digest_w0 = key[0];
		req.digest_w1 = key[1];
		req.digest_w2 = key[2];
		req.digest_w3 = key[3];
		req.offset_in = off;
		return req;
	endfunction

	// Mostly puts and gets on a small pool of crowded keys, with some misses,
	// some new keys, clears, the unused command and the all-zero digest.
	function automatic in_t mixed_request();
		digest_t     k;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (pick < 40)
			return make_req(CMD_PUT, k, rand_offset());
		if (pick < 72)
			return make_req(CMD_GET, k, rand_offset());
		if (pick < 82)
			return make_req(CMD_GET, pool_key(pool_base), rand_offset());
		if (pick < 90)
			return make_req(CMD_PUT, pool_key(pool_base), rand_offset());
		if (pick < 94)
			return make_req(CMD_CLEAR, fresh_key(), rand_offset());
		if (pick < 97)
			return make_req(CMD_NONE, fresh_key(), rand_offset());
		return make_req($urandom_range(0, 1) ? CMD_PUT : CMD_GET, '0, rand_offset());
	endfunction

	// Offers one request and returns once it has been accepted. valid is only
	// dropped for a gap between bursts, so a request that follows at once
	// keeps valid high without a glitch.
	task automatic send(in_t req);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
			if (!steady_send) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= req;
		do
			@(posedge clk);
		while (!in_ready);
		table_model.note_request(req);
	endtask

	// Stops offering and waits until every outstanding response is back.
	task automatic drain();
		in_valid <= 1'b0;
		while (table_model.pending_resps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the capacity register and reads it back. Only called with the
	// block idle.
	task automatic write_capacity(logic [CNT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== 32'(value)) begin
			table_model.failures++;
			$error("capacity readback mismatch: expected %0d, got %0d", value, prdata);
		end
		table_model.capacity = value;
	endtask

	task automatic run_mixed(int unsigned count);
		int unsigned n;
		key_pool.delete();
		pool_base = $urandom_range(0, SLOTS - 1);
		for (n = 0; n < 32; n++)
			key_pool.push_back(pool_key(pool_base));
		for (n = 0; n < count; n++)
			send(mixed_request());
	endtask

	initial begin : stimulus
		digest_t     key_a;
		digest_t     key_b;
		digest_t     key_c;
		digest_t     key_d;
		digest_t     zero_key;
		digest_t     k;
		int          slot;
		int unsigned pick;
		int unsigned guard;
		int          w;

		table_model = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset capacity. Key A has every word at
		// its maximum, so all its probes land on the last slot. Key C lands
		// on the same slot for every probe and must wrap round to slot 0;
		// key D does the same and is never stored, so its get walks on until
		// it meets an empty slot.
		zero_key = '0;
		key_a = {4{64'hFFFF_FFFF_FFFF_FFFF}};
		key_b = fresh_key();
		for (w = 0; w < 4; w++) begin
			key_c[w] = word_at(SLOTS - 1);
			key_d[w] = word_at(SLOTS - 1);
		end
		send(make_req(CMD_GET, zero_key, MOST_POS));
		// The zero digest takes a slot in the count but leaves it empty.
		send(make_req(CMD_PUT, zero_key, MOST_NEG));
		send(make_req(CMD_GET, zero_key, 64'd0));
		send(make_req(CMD_PUT, key_a, MOST_POS));
		send(make_req(CMD_PUT, key_a, 64'd0));
		send(make_req(CMD_GET, key_a, 64'd0));
		send(make_req(CMD_PUT, key_b, -64'sd5));
		send(make_req(CMD_PUT, key_b, 64'd7));
		send(make_req(CMD_GET, key_b, MOST_NEG));
		send(make_req(CMD_PUT, key_c, '1));
		send(make_req(CMD_GET, key_c, 64'd0));
		send(make_req(CMD_GET, key_d, 64'd0));
		send(make_req(CMD_NONE, key_a, MOST_POS));
		send(make_req(CMD_CLEAR, key_b, 64'd0));
		send(make_req(CMD_GET, key_a, 64'd0));
		drain();

		// With no capacity at all every new key is refused, the zero digest
		// included.
		write_capacity('0);
		send(make_req(CMD_PUT, key_b, 64'd1));
		send(make_req(CMD_PUT, zero_key, 64'd1));
		send(make_req(CMD_GET, key_b, 64'd0));
		drain();

		// Room for two: the third new key is refused, but a key already held
		// is still updated while the table counts as full.
		write_capacity(11'd2);
		send(make_req(CMD_PUT, key_a, 64'd1));
		send(make_req(CMD_PUT, key_b, MOST_NEG));
		send(make_req(CMD_PUT, key_c, 64'd3));
		send(make_req(CMD_PUT, key_a, 64'd9));
		send(make_req(CMD_GET, key_c, 64'd0));
		send(make_req(CMD_CLEAR, zero_key, 64'd0));
		drain();

		// Random traffic at a small capacity. It opens with a long receiver
		// hold-off while the sender keeps offering, so that the block backs
		// up and holds off its input.
		write_capacity(CNT_W'($urandom_range(1, 40)));
		steady_send = 1'b1;
		hold_req <= hold_req + 1;
		run_mixed(40);
		steady_send = 1'b0;
		run_mixed(70);
		drain();

		// Fill the whole table at full capacity. Most new keys aim their
		// first probe at an empty slot so the fill stays quick; the rest are
		// random keys, and gets and updates of stored keys are mixed in.
		// Random keys stop once the table is dense, where their searches
		// would grow long.
		write_capacity(11'(SLOTS));
		send(make_req(CMD_CLEAR, zero_key, 64'd0));
		guard = 0;
		while (table_model.entries < SLOTS && guard < 2 * SLOTS) begin
			guard++;
			pick = $urandom_range(0, 99);
			if (pick < 4 && table_model.stored_keys.size() != 0) begin
				k = table_model.stored_keys[$urandom_range(0,
					table_model.stored_keys.size() - 1)];
				send(make_req(pick < 2 ? CMD_GET : CMD_PUT, k, rand_offset()));
			end else if (pick < 14 && table_model.entries < 900) begin
				send(make_req(pick < 6 ? CMD_GET : CMD_PUT, fresh_key(), rand_offset()));
			end else begin
				slot = table_model.free_slot();
				k = fresh_key();
				if (slot >= 0)
					k[0] = word_at(slot);
				send(make_req(CMD_PUT, k, rand_offset()));
			end
		end

		// With every slot taken, a new key finds neither its digest nor an
		// empty slot: a put reports no slot and a get walks the whole table
		// before reporting not found. Keys already stored still work.
		k = table_model.stored_keys[$urandom_range(0, table_model.stored_keys.size() - 1)];
		send(make_req(CMD_PUT, fresh_key(), 64'd5));
		send(make_req(CMD_PUT, k, MOST_POS));
		send(make_req(CMD_GET, fresh_key(), 64'd0));
		send(make_req(CMD_GET, k, 64'd0));
		send(make_req(CMD_PUT, zero_key, 64'd0));
		drain();

		// A capacity below the present count refuses new keys, but here the
		// search fails first for lack of a slot.
		write_capacity(11'd1000);
		send(make_req(CMD_PUT, fresh_key(), 64'd2));
		send(make_req(CMD_PUT, k, 64'd3));
		send(make_req(CMD_GET, k, 64'd0));
		send(make_req(CMD_CLEAR, zero_key, 64'd0));
		drain();

		// Last random stretch on a fresh pool and a tight capacity.
		write_capacity(11'd1023);
		write_capacity(CNT_W'($urandom_range(4, 24)));
		run_mixed(60);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d requests (put %0d, get %0d, clear %0d, unused %0d),",
			table_model.cmd_seen[CMD_PUT] + table_model.cmd_seen[CMD_GET] +
			table_model.cmd_seen[CMD_CLEAR] + table_model.cmd_seen[CMD_NONE],
			table_model.cmd_seen[CMD_PUT], table_model.cmd_seen[CMD_GET],
			table_model.cmd_seen[CMD_CLEAR], table_model.cmd_seen[CMD_NONE]);
		$display("  responses ok %0d, not found %0d, full %0d, no slot %0d; %0d failures.",
			table_model.status_seen[ST_OK], table_model.status_seen[ST_NOT_FOUND],
			table_model.status_seen[ST_FULL], table_model.status_seen[ST_NO_SLOT],
			table_model.failures);
		if (table_model.failures == 0 && table_model.pending_resps.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
